// File: src/cc2p_pkg.sv
// cc2p_pkg: shared constants, arctangent table and types of the cartesian-to-polar unit
`timescale 1ns / 1ps
`default_nettype none

package cc2p_pkg;

    // default configuration
    localparam int DEF_ITERATIONS      = 16;
    localparam int DEF_DATA_WIDTH      = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 8;

    // fixed-point formats of the datapath
    localparam int GUARD_BITS  = 16;
    localparam int Z_FRAC_BITS = 16;
    localparam int Z_WIDTH     = 24;
    localparam int TABLE_LEN   = 24;

    // gain 0.607252941 in q30
    localparam int             GAIN_FRAC_BITS = 30;
    localparam logic [29:0]    GAIN_Q30       = 30'd652032881;

    // atan(2^-i) in degrees, q16
    localparam logic signed [Z_WIDTH-1:0] ATAN_TABLE [TABLE_LEN] = '{
        24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945,
        24'sd234379,  24'sd117304,  24'sd58666,  24'sd29335,
        24'sd14668,   24'sd7334,    24'sd3667,   24'sd1833,
        24'sd917,     24'sd458,     24'sd229,    24'sd115,
        24'sd57,      24'sd29,      24'sd14,     24'sd7,
        24'sd4,       24'sd2,       24'sd1,      24'sd0
    };

    // half-plane fold applied to the input point
    typedef enum logic [1:0] {
        QUAD_NONE        = 2'd0,
        QUAD_LOWER_LEFT  = 2'd1,
        QUAD_UPPER_LEFT  = 2'd2
    } t_quad;

    // side information that rides along with each transaction
    typedef struct packed {
        logic  origin;
        t_quad quad;
    } t_side;

endpackage

`default_nettype wire

// File: src/cordic_cartesian_to_polar_unit.sv
// cordic_cartesian_to_polar_unit: pipelined cordic vectoring, cartesian point to radius and angle
//
//  channel  direction  handshake                   payload
//  input    in         i_in_valid / o_in_ready     i_x_coord, i_y_coord (signed)
//  output   out        o_out_valid / i_out_ready   o_magnitude (unsigned), o_angle_deg (signed)
//
// one transaction enters per clock unless the output stalls; the stages in order are
// the fold stage, one cell per micro-rotation and two output stages for the gain product
// every stage has its own valid bit and a ready that ripples back along the chain,
// so a stalled output only blocks stages that are full and bubbles still fill up
// synchronous active-low reset clears all valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module cordic_cartesian_to_polar_unit import cc2p_pkg::*; #(
    parameter int ITERATIONS      = DEF_ITERATIONS,
    parameter int DATA_WIDTH      = DEF_DATA_WIDTH,
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] i_x_coord,
    input  wire logic signed [DATA_WIDTH-1:0] i_y_coord,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [DATA_WIDTH-1:0]             o_magnitude,
    output logic signed [ANGLE_FRAC_BITS+8:0] o_angle_deg
);

    localparam int XW = DATA_WIDTH + GUARD_BITS + 3;
    localparam int AW = ANGLE_FRAC_BITS + 9;
    localparam int ANGLE_LIM = 180 * (2 ** ANGLE_FRAC_BITS);

    logic [ITERATIONS:0]       v_s;
    logic [ITERATIONS:0]       ready_s;
    logic signed [XW-1:0]      x_s    [ITERATIONS+1];
    logic signed [XW-1:0]      y_s    [ITERATIONS+1];
    logic signed [Z_WIDTH-1:0] z_s    [ITERATIONS+1];
    t_side                     side_s [ITERATIONS+1];

    // fold and scale
    cc2p_entry #(
        .DW (DATA_WIDTH),
        .XW (XW)
    ) u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .o_valid (v_s[0]),
        .i_ready (ready_s[0]),
        .o_x     (x_s[0]),
        .o_y     (y_s[0]),
        .o_side  (side_s[0])
    );

    assign z_s[0] = '0;

    // chain of micro-rotation cells
    generate
        for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
            cc2p_cell #(
                .STAGE (k),
                .XW    (XW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (v_s[k]),
                .o_ready (ready_s[k]),
                .i_x     (x_s[k]),
                .i_y     (y_s[k]),
                .i_z     (z_s[k]),
                .i_side  (side_s[k]),
                .o_valid (v_s[k+1]),
                .i_ready (ready_s[k+1]),
                .o_x     (x_s[k+1]),
                .o_y     (y_s[k+1]),
                .o_z     (z_s[k+1]),
                .o_side  (side_s[k+1])
            );
        end
    endgenerate

    // angle fold-back and radius scaling
    cc2p_exit #(
        .DW  (DATA_WIDTH),
        .AFB (ANGLE_FRAC_BITS),
        .XW  (XW),
        .AW  (AW)
    ) u_exit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v_s[ITERATIONS]),
        .o_ready     (ready_s[ITERATIONS]),
        .i_x         (x_s[ITERATIONS]),
        .i_z         (z_s[ITERATIONS]),
        .i_side      (side_s[ITERATIONS]),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_magnitude (o_magnitude),
        .o_angle     (o_angle_deg)
    );

    // input side only backs up when every stage of the chain is full
    a_ready_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&v_s))
        else $error("input stalled while the chain has a bubble");

    // x is never negative at the end of the vectoring chain
    a_x_nonnegative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_s[ITERATIONS] |-> !x_s[ITERATIONS][XW-1])
        else $error("negative x at the end of the chain");

    // delivered angle stays within +/-180 degrees
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_angle_deg) <= ANGLE_LIM &&
                         $signed(o_angle_deg) >= -ANGLE_LIM))
        else $error("angle out of range");

    // reset empties the whole pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && v_s == '0))
        else $error("transaction survived reset");

endmodule

`default_nettype wire

// File: src/cc2p_entry.sv
// cc2p_entry: input stage, folds the point into the right half-plane and scales it
`timescale 1ns / 1ps
`default_nettype none

module cc2p_entry import cc2p_pkg::*; #(
    parameter int DW = DEF_DATA_WIDTH,
    parameter int XW = DEF_DATA_WIDTH + GUARD_BITS + 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [DW-1:0] i_x,
    input  wire logic signed [DW-1:0] i_y,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [XW-1:0]      o_x,
    output logic signed [XW-1:0]      o_y,
    output t_side                     o_side
);

    logic                 r_valid;
    logic signed [XW-1:0] r_x, n_x;
    logic signed [XW-1:0] r_y, n_y;
    t_side                r_side, n_side;
    logic signed [DW:0]   x_abs;

    assign o_ready = !r_valid || i_ready;

    // mirror a left-half point and add guard bits
    always_comb begin
        x_abs = (DW + 1)'(i_x);
        if (i_x[DW-1]) begin
            x_abs = -x_abs;
        end
        n_x = XW'(x_abs) <<< GUARD_BITS;
        n_y = XW'(i_y) <<< GUARD_BITS;
        n_side.origin = (i_x == '0) && (i_y == '0);
        if (!i_x[DW-1]) begin
            n_side.quad = QUAD_NONE;
        end else if (i_y[DW-1]) begin
            n_side.quad = QUAD_LOWER_LEFT;
        end else begin
            n_side.quad = QUAD_UPPER_LEFT;
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: src/cc2p_cell.sv
// cc2p_cell: one vectoring micro-rotation with its own pipeline register
`timescale 1ns / 1ps
`default_nettype none

module cc2p_cell import cc2p_pkg::*; #(
    parameter int STAGE = 0,
    parameter int XW    = DEF_DATA_WIDTH + GUARD_BITS + 3
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [XW-1:0]      i_x,
    input  wire logic signed [XW-1:0]      i_y,
    input  wire logic signed [Z_WIDTH-1:0] i_z,
    input  wire t_side                     i_side,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [XW-1:0]           o_x,
    output logic signed [XW-1:0]           o_y,
    output logic signed [Z_WIDTH-1:0]      o_z,
    output t_side                          o_side
);

    logic                      r_valid;
    logic signed [XW-1:0]      r_x, n_x;
    logic signed [XW-1:0]      r_y, n_y;
    logic signed [Z_WIDTH-1:0] r_z, n_z;
    t_side                     r_side;
    logic signed [XW-1:0]      dx, dy;

    assign o_ready = !r_valid || i_ready;

    // rotate towards y = 0, direction from the sign of y
    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (!i_y[XW-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN_TABLE[STAGE];
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN_TABLE[STAGE];
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: src/cc2p_exit.sv
// cc2p_exit: angle rounding and fold-back, gain scaling and saturation of the radius
`timescale 1ns / 1ps
`default_nettype none

module cc2p_exit import cc2p_pkg::*; #(
    parameter int DW  = DEF_DATA_WIDTH,
    parameter int AFB = DEF_ANGLE_FRAC_BITS,
    parameter int XW  = DEF_DATA_WIDTH + GUARD_BITS + 3,
    parameter int AW  = DEF_ANGLE_FRAC_BITS + 9
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [XW-1:0]      i_x,
    input  wire logic signed [Z_WIDTH-1:0] i_z,
    input  wire t_side                     i_side,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [DW-1:0]                  o_magnitude,
    output logic signed [AW-1:0]           o_angle
);

    localparam int SH  = Z_FRAC_BITS - AFB;
    localparam int EW  = Z_WIDTH + 2;
    localparam int HW  = XW - 1 - GUARD_BITS;
    localparam int PHW = HW + GAIN_FRAC_BITS;
    localparam int PLW = GUARD_BITS + GAIN_FRAC_BITS;
    localparam int SW  = PHW + GUARD_BITS + 1;
    localparam int RSH = GAIN_FRAC_BITS + GUARD_BITS;
    localparam logic signed [EW-1:0] LIM = EW'(180 * (2 ** AFB));

    logic                  r_a_valid, r_b_valid;
    logic                  a_ready;
    logic [PHW-1:0]        r_pp_hi, n_pp_hi;
    logic [PLW-1:0]        r_pp_lo, n_pp_lo;
    logic signed [AW-1:0]  r_angle, n_angle;
    logic [DW-1:0]         r_mag, n_mag;
    logic [XW-2:0]         xf;
    logic signed [EW-1:0]  zs;
    logic signed [EW-1:0]  ang;
    logic [SW-1:0]         sum;
    logic [SW-1:0]         mag_full;

    assign a_ready = !r_b_valid || i_ready;
    assign o_ready = !r_a_valid || a_ready;

    // round z from q16 to the output fraction, half up
    generate
        if (SH > 0) begin : g_round
            assign zs = (EW'(i_z) + (EW'(1) <<< (SH - 1))) >>> SH;
        end else begin : g_noround
            assign zs = EW'(i_z);
        end
    endgenerate

    // stage a: fold the angle back, split the gain product
    always_comb begin
        case (i_side.quad)
            QUAD_UPPER_LEFT: ang = LIM - zs;
            QUAD_LOWER_LEFT: ang = -LIM - zs;
            default:         ang = zs;
        endcase
        if (ang > LIM) begin
            ang = LIM;
        end else if (ang < -LIM) begin
            ang = -LIM;
        end
        if (i_side.origin) begin
            ang = '0;
        end
        n_angle = ang[AW-1:0];

        xf = (i_side.origin || i_x[XW-1]) ? '0 : i_x[XW-2:0];
        n_pp_hi = PHW'(xf[XW-2:GUARD_BITS]) * PHW'(GAIN_Q30);
        n_pp_lo = PLW'(xf[GUARD_BITS-1:0]) * PLW'(GAIN_Q30);
    end

    // stage b: sum partial products, round half up, saturate
    always_comb begin
        sum = (SW'(r_pp_hi) << GUARD_BITS) + SW'(r_pp_lo) + (SW'(1) << (RSH - 1));
        mag_full = sum >> RSH;
        if (|mag_full[SW-1:DW]) begin
            n_mag = '1;
        end else begin
            n_mag = mag_full[DW-1:0];
        end
    end

    // occupancy of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (a_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // payload of both stages
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pp_hi <= n_pp_hi;
            r_pp_lo <= n_pp_lo;
            r_angle <= n_angle;
        end
        if (r_a_valid && a_ready) begin
            r_mag   <= n_mag;
            o_angle <= r_angle;
        end
    end

    assign o_valid     = r_b_valid;
    assign o_magnitude = r_mag;

endmodule

`default_nettype wire
